// ===== hw/rtl/ecef_to_ned_rotate_covariance_unit_assert.svh =====
// Assertion macros shared by the rotation unit RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ECEF_TO_NED_ROTATE_COVARIANCE_UNIT_ASSERT_SVH
`define ECEF_TO_NED_ROTATE_COVARIANCE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define E2N_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define E2N_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define E2N_ASSERT(lbl, clk, rst_n, prop, msg)
`define E2N_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/e2n_pkg.sv =====
// Shared widths, types, register codes and saturation for the rotation unit.
// No dependencies.
package e2n_pkg;

  localparam int CoefW   = 32;  // Q1.30 coefficients
  localparam int DataW   = 40;  // vector and covariance entries
  localparam int TW      = DataW + 4;  // intermediate R*P entries
  localparam int SumW    = TW + 4;     // final dot products before saturation
  localparam int SplitW  = 22;  // low slice of the data operand in a product
  localparam int RndShift = 30; // Q1.30 scaling
  localparam int CfgIdxW = 3;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [DataW-1:0] data_t;

  // Load enables for the three register stages of a dot product
  typedef struct packed {
    logic mul;  // partial products
    logic rnd;  // recombined and rounded products
    logic sum;  // sum of three
  } stg_en_t;

  localparam logic [CfgIdxW-1:0] CfgNorthX = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgNorthY = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgNorthZ = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgEastX  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgEastY  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDownX  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgDownY  = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgDownZ  = 3'd7;

  // Clamp a wide signed sum to the 40-bit signed range
  function automatic data_t sat_data(input logic signed [SumW-1:0] v);
    logic [SumW-DataW:0] upper;
    data_t res;
    upper = v[SumW-1:DataW-1];
    if ((&upper) || !(|upper)) begin
      res = v[DataW-1:0];
    end else if (v[SumW-1]) begin
      res = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      res = {1'b0, {(DataW-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/e2n_rmul.sv =====
// Two-stage Q1.30 product: split partial products, then recombine and round.
// Depends on e2n_pkg.
module e2n_rmul #(
  parameter int DW = 40
) (
  input  logic                 clk_i,
  input  logic                 ld_mul_i,
  input  logic                 ld_rnd_i,
  input  e2n_pkg::coef_t       coef_i,
  input  logic signed [DW-1:0] data_i,
  output logic signed [DW+1:0] prod_o
);
  import e2n_pkg::*;

  localparam int HiW = DW - SplitW;
  localparam int PW  = CoefW + DW;
  localparam int RW  = DW + 2;

  logic [SplitW-1:0]              lo;
  logic signed [HiW-1:0]          hi;
  logic signed [CoefW+SplitW:0]   pl_q;
  logic signed [CoefW+HiW-1:0]    ph_q;
  logic signed [PW-1:0]           prod;
  logic signed [PW-1:0]           half;
  logic signed [PW-1:0]           rnd;
  logic signed [RW-1:0]           prod_q;

  assign lo = data_i[SplitW-1:0];
  assign hi = data_i[DW-1:SplitW];

  always_ff @(posedge clk_i) begin
    if (ld_mul_i) begin
      pl_q <= coef_i * $signed({1'b0, lo});
      ph_q <= coef_i * hi;
    end
  end

  // Round to nearest, ties away from zero: add half, or half minus one below zero
  always_comb begin
    prod = $signed({ph_q, {SplitW{1'b0}}}) + PW'(pl_q);
    half = PW'(1) << (RndShift - 1);
    rnd  = prod + half - PW'(prod[PW-1]);
  end

  always_ff @(posedge clk_i) begin
    if (ld_rnd_i) begin
      prod_q <= rnd[RndShift +: RW];
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== hw/rtl/e2n_dot3.sv =====
// Three-term rounded dot product, three register stages deep.
// Depends on e2n_pkg and e2n_rmul.
module e2n_dot3 #(
  parameter int DW = 40
) (
  input  logic                 clk_i,
  input  e2n_pkg::stg_en_t     en_i,
  input  e2n_pkg::coef_t       coef_i [3],
  input  logic signed [DW-1:0] data_i [3],
  output logic signed [DW+3:0] sum_o
);
  import e2n_pkg::*;

  localparam int RW = DW + 2;
  localparam int SW = DW + 4;

  logic signed [RW-1:0] prod [3];
  logic signed [SW-1:0] sum_q;

  for (genvar i = 0; i < 3; i++) begin : g_term
    e2n_rmul #(.DW(DW)) u_rmul (
      .clk_i   (clk_i),
      .ld_mul_i(en_i.mul),
      .ld_rnd_i(en_i.rnd),
      .coef_i  (coef_i[i]),
      .data_i  (data_i[i]),
      .prod_o  (prod[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      sum_q <= SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]);
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== hw/rtl/ecef_to_ned_rotate_covariance_unit.sv =====
// Top level: Earth-fixed to north/east/down rotation with covariance R*P*R^T.
// Depends on e2n_pkg, e2n_dot3 (and e2n_rmul below it), and the assert header.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   input    | start_i, busy_o    | vec_*_i, cov_*_i, cov_present_i
//   result   | res_valid_o strobe | north_o east_o down_o cov_*_o cov_valid_o
//   config   | cfg_we_i           | cfg_idx_i, cfg_wdata_i (Q1.30 entries)
//
// One transaction enters per cycle; busy_o stays low. Seven register stages
// follow the ports: two dot-product passes of three stages each (partial
// products, round, sum) plus the output register. The first stage loads at the
// accepting edge, and the result strobe rises as the output register loads.
// Reset clears the valid pipeline and the matrix registers; data registers
// carry no reset.
// The receiver cannot stall, so nothing in the pipe ever waits.
`include "ecef_to_ned_rotate_covariance_unit_assert.svh"

module ecef_to_ned_rotate_covariance_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [e2n_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [e2n_pkg::CoefW-1:0]            cfg_wdata_i,
  // command side
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  e2n_pkg::data_t                       vec_x_i,
  input  e2n_pkg::data_t                       vec_y_i,
  input  e2n_pkg::data_t                       vec_z_i,
  input  e2n_pkg::data_t                       cov_xx_i,
  input  e2n_pkg::data_t                       cov_xy_i,
  input  e2n_pkg::data_t                       cov_xz_i,
  input  e2n_pkg::data_t                       cov_yy_i,
  input  e2n_pkg::data_t                       cov_yz_i,
  input  e2n_pkg::data_t                       cov_zz_i,
  input  logic                                 cov_present_i,
  // result side
  output logic                                 res_valid_o,
  output e2n_pkg::data_t                       north_o,
  output e2n_pkg::data_t                       east_o,
  output e2n_pkg::data_t                       down_o,
  output e2n_pkg::data_t                       cov_nn_o,
  output e2n_pkg::data_t                       cov_ne_o,
  output e2n_pkg::data_t                       cov_nd_o,
  output e2n_pkg::data_t                       cov_ee_o,
  output e2n_pkg::data_t                       cov_ed_o,
  output e2n_pkg::data_t                       cov_dd_o,
  output logic                                 cov_valid_o
);
  import e2n_pkg::*;

  localparam int VSW = DataW + 4;  // first-pass sum width, equals TW
  localparam int NStg = 7;

  // ---------------------------------------------------------------------------
  // Rotation matrix registers. East-z is structurally zero.
  // ---------------------------------------------------------------------------
  coef_t nx_q, ny_q, nz_q, ex_q, ey_q, dx_q, dy_q, dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q <= '0; ny_q <= '0; nz_q <= '0;
      ex_q <= '0; ey_q <= '0;
      dx_q <= '0; dy_q <= '0; dz_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgNorthX: nx_q <= cfg_wdata_i;
        CfgNorthY: ny_q <= cfg_wdata_i;
        CfgNorthZ: nz_q <= cfg_wdata_i;
        CfgEastX:  ex_q <= cfg_wdata_i;
        CfgEastY:  ey_q <= cfg_wdata_i;
        CfgDownX:  dx_q <= cfg_wdata_i;
        CfgDownY:  dy_q <= cfg_wdata_i;
        CfgDownZ:  dz_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  coef_t rmat [3][3];

  always_comb begin
    rmat[0][0] = nx_q; rmat[0][1] = ny_q; rmat[0][2] = nz_q;
    rmat[1][0] = ex_q; rmat[1][1] = ey_q; rmat[1][2] = '0;
    rmat[2][0] = dx_q; rmat[2][1] = dy_q; rmat[2][2] = dz_q;
  end

  // ---------------------------------------------------------------------------
  // Valid pipeline and the cov_present bit that travels alongside it.
  // Bit k is high while stage k holds a live transaction.
  // ---------------------------------------------------------------------------
  logic            accept;
  logic [NStg-1:0] vld_q;
  logic [NStg-2:0] cp_q;

  assign busy_o = 1'b0;  // fully pipelined: a transaction can enter every cycle
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NStg-2:0], accept};
    end
  end

  // Advance every cycle; only meaningful where the matching valid bit is set
  always_ff @(posedge clk_i) begin
    cp_q <= {cp_q[NStg-3:0], cov_present_i};
  end

  stg_en_t en_a, en_b;

  assign en_a = '{mul: accept,   rnd: vld_q[0], sum: vld_q[1]};
  assign en_b = '{mul: vld_q[2], rnd: vld_q[3], sum: vld_q[4]};

  // ---------------------------------------------------------------------------
  // First pass: vector rotation and T = R * P, straight from the ports.
  // ---------------------------------------------------------------------------
  data_t                 vec [3];
  data_t                 pmat [3][3];
  logic signed [VSW-1:0] vsum [3];
  logic signed [TW-1:0]  tmat [3][3];

  always_comb begin
    vec[0] = vec_x_i; vec[1] = vec_y_i; vec[2] = vec_z_i;
    pmat[0][0] = cov_xx_i; pmat[0][1] = cov_xy_i; pmat[0][2] = cov_xz_i;
    pmat[1][0] = cov_xy_i; pmat[1][1] = cov_yy_i; pmat[1][2] = cov_yz_i;
    pmat[2][0] = cov_xz_i; pmat[2][1] = cov_yz_i; pmat[2][2] = cov_zz_i;
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    e2n_dot3 #(.DW(DataW)) u_vec (
      .clk_i (clk_i),
      .en_i  (en_a),
      .coef_i(rmat[i]),
      .data_i(vec),
      .sum_o (vsum[i])
    );

    // T[i][j] pairs row i of R with column j of P
    for (genvar j = 0; j < 3; j++) begin : g_col
      data_t pcol [3];

      assign pcol[0] = pmat[0][j];
      assign pcol[1] = pmat[1][j];
      assign pcol[2] = pmat[2][j];

      e2n_dot3 #(.DW(DataW)) u_t (
        .clk_i (clk_i),
        .en_i  (en_a),
        .coef_i(rmat[i]),
        .data_i(pcol),
        .sum_o (tmat[i][j])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // Second pass: upper triangle of T * R^T. Entry (i,k) is row k of R
  // against row i of T.
  // ---------------------------------------------------------------------------
  logic signed [SumW-1:0] c_nn, c_ne, c_nd, c_ee, c_ed, c_dd;

  e2n_dot3 #(.DW(TW)) u_nn (
    .clk_i(clk_i), .en_i(en_b), .coef_i(rmat[0]), .data_i(tmat[0]), .sum_o(c_nn)
  );
  e2n_dot3 #(.DW(TW)) u_ne (
    .clk_i(clk_i), .en_i(en_b), .coef_i(rmat[1]), .data_i(tmat[0]), .sum_o(c_ne)
  );
  e2n_dot3 #(.DW(TW)) u_nd (
    .clk_i(clk_i), .en_i(en_b), .coef_i(rmat[2]), .data_i(tmat[0]), .sum_o(c_nd)
  );
  e2n_dot3 #(.DW(TW)) u_ee (
    .clk_i(clk_i), .en_i(en_b), .coef_i(rmat[1]), .data_i(tmat[1]), .sum_o(c_ee)
  );
  e2n_dot3 #(.DW(TW)) u_ed (
    .clk_i(clk_i), .en_i(en_b), .coef_i(rmat[2]), .data_i(tmat[1]), .sum_o(c_ed)
  );
  e2n_dot3 #(.DW(TW)) u_dd (
    .clk_i(clk_i), .en_i(en_b), .coef_i(rmat[2]), .data_i(tmat[2]), .sum_o(c_dd)
  );

  // ---------------------------------------------------------------------------
  // Saturate the rotated vector and hold it while the covariance catches up.
  // ---------------------------------------------------------------------------
  data_t vdly_q [3][3];  // [delay stage][component]

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (vld_q[2]) vdly_q[0][c] <= sat_data(SumW'(vsum[c]));
      if (vld_q[3]) vdly_q[1][c] <= vdly_q[0][c];
      if (vld_q[4]) vdly_q[2][c] <= vdly_q[1][c];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. Covariance fields drop to zero when not requested.
  // ---------------------------------------------------------------------------
  data_t north_q, east_q, down_q;
  data_t nn_q, ne_q, nd_q, ee_q, ed_q, dd_q;
  logic  cov_valid_q;
  logic  cp_out;

  assign cp_out = cp_q[NStg-2];

  always_ff @(posedge clk_i) begin
    if (vld_q[5]) begin
      north_q     <= vdly_q[2][0];
      east_q      <= vdly_q[2][1];
      down_q      <= vdly_q[2][2];
      nn_q        <= cp_out ? sat_data(c_nn) : '0;
      ne_q        <= cp_out ? sat_data(c_ne) : '0;
      nd_q        <= cp_out ? sat_data(c_nd) : '0;
      ee_q        <= cp_out ? sat_data(c_ee) : '0;
      ed_q        <= cp_out ? sat_data(c_ed) : '0;
      dd_q        <= cp_out ? sat_data(c_dd) : '0;
      cov_valid_q <= cp_out;
    end
  end

  assign res_valid_o = vld_q[NStg-1];
  assign north_o     = north_q;
  assign east_o      = east_q;
  assign down_o      = down_q;
  assign cov_nn_o    = nn_q;
  assign cov_ne_o    = ne_q;
  assign cov_nd_o    = nd_q;
  assign cov_ee_o    = ee_q;
  assign cov_ed_o    = ed_q;
  assign cov_dd_o    = dd_q;
  assign cov_valid_o = cov_valid_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `E2N_ASSERT(a_latency, clk_i, rst_ni, accept |-> ##7 res_valid_o,
              "accepted transaction did not produce a result after 7 cycles")
  `E2N_ASSERT(a_no_phantom, clk_i, rst_ni, res_valid_o |-> $past(accept, 7),
              "result strobe without a matching accepted transaction")
  `E2N_ASSERT(a_cov_zero, clk_i, rst_ni,
              (res_valid_o && !cov_valid_o) |-> (cov_nn_o == '0 && cov_ne_o == '0 &&
              cov_nd_o == '0 && cov_ee_o == '0 && cov_ed_o == '0 && cov_dd_o == '0),
              "covariance outputs nonzero without covariance request")
  `E2N_ASSERT_ALWAYS(a_rst_clear, clk_i, $past(!rst_ni) |-> (vld_q == '0),
                     "valid pipeline not cleared during reset")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the Earth-fixed to north/east/down rotation unit.
// Depends on e2n_pkg and the ecef_to_ned_rotate_covariance_unit RTL.
// Predicts each transaction in a scoreboard class and compares every result field.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import e2n_pkg::*;

  // One command transaction: vector, six unique covariance entries, request flag
  typedef struct {
    data_t vec [3];          // x, y, z
    data_t cov [6];          // xx, xy, xz, yy, yz, zz
    logic  cov_present;
  } ecef_cmd_t;

  // One result transaction: north, east, down, then nn, ne, nd, ee, ed, dd
  typedef struct {
    data_t val [9];
    logic  cov_valid;
  } ned_result_t;

  // Register write order; rot_words below follows the same order
  localparam logic [CfgIdxW-1:0] CoefOrder [8] = '{
    CfgNorthX, CfgNorthY, CfgNorthZ, CfgEastX, CfgEastY, CfgDownX, CfgDownY, CfgDownZ
  };

  localparam int ResultLatency  = 7;
  localparam int SettleCycles   = ResultLatency + 5;
  localparam int RandomPhases   = 10;
  localparam int ItemsPerPhase  = 124;

  localparam logic [CoefW-1:0] CoefOne    = 32'h4000_0000;
  localparam logic [CoefW-1:0] CoefNegTwo = 32'h8000_0000;
  localparam logic [CoefW-1:0] CoefMax    = 32'h7FFF_FFFF;
  localparam logic [CoefW-1:0] CoefHalf   = 32'h2000_0000;
  localparam logic [CoefW-1:0] CoefRoot2  = 32'd759250125;  // 0.7071 in Q1.30

  localparam data_t DataMax = {1'b0, {(DataW-1){1'b1}}};
  localparam data_t DataMin = {1'b1, {(DataW-1){1'b0}}};
  localparam data_t TieHalf = 40'sd536870912;  // 2^29: half an LSB after the Q1.30 shift

  // ---------------------------------------------------------------------------
  // Scoreboard: own copy of the rotation matrix, predicted results in order
  // ---------------------------------------------------------------------------
  class ned_rotation_sb;
    longint      coef [3][3];
    ned_result_t pending_ned [$];
    int          mismatches;
    string       field_name [9];

    function new();
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          coef[i][j] = 0;
        end
      end
      mismatches = 0;
      field_name = '{"north", "east", "down", "cov_nn", "cov_ne", "cov_nd",
                     "cov_ee", "cov_ed", "cov_dd"};
    endfunction

    // Mirror a register write; east row z stays zero
    function void write_coef(logic [CfgIdxW-1:0] idx, logic [CoefW-1:0] word);
      longint v;
      v = longint'(signed'(word));
      case (idx)
        CfgNorthX: coef[0][0] = v;
        CfgNorthY: coef[0][1] = v;
        CfgNorthZ: coef[0][2] = v;
        CfgEastX:  coef[1][0] = v;
        CfgEastY:  coef[1][1] = v;
        CfgDownX:  coef[2][0] = v;
        CfgDownY:  coef[2][1] = v;
        CfgDownZ:  coef[2][2] = v;
        default: ;
      endcase
    endfunction

    // round(c * d / 2^30), ties away from zero, computed on magnitudes
    function longint mul_q30(longint c, longint d);
      logic         neg;
      logic [63:0]  mc, md;
      logic [127:0] prod;
      neg  = (c < 0) != (d < 0);
      mc   = (c < 0) ? -c : c;
      md   = (d < 0) ? -d : d;
      prod = ({64'd0, mc} * {64'd0, md} + (128'd1 << 29)) >> 30;
      return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function longint dot_row(int row, longint a, longint b, longint c);
      return mul_q30(coef[row][0], a) + mul_q30(coef[row][1], b) + mul_q30(coef[row][2], c);
    endfunction

    function data_t clamp40(longint v);
      if (v > longint'(DataMax)) return DataMax;
      if (v < longint'(DataMin)) return DataMin;
      return data_t'(v);
    endfunction

    function ned_result_t rotate_to_ned(ecef_cmd_t c);
      ned_result_t r;
      longint      v [3];
      longint      p [3][3];
      longint      t [3][3];
      int          k;
      for (int i = 0; i < 3; i++) v[i] = c.vec[i];
      for (int i = 0; i < 3; i++) r.val[i] = clamp40(dot_row(i, v[0], v[1], v[2]));
      for (int i = 3; i < 9; i++) r.val[i] = '0;
      r.cov_valid = c.cov_present;
      if (!c.cov_present) return r;
      p[0][0] = c.cov[0];
      p[0][1] = c.cov[1]; p[1][0] = c.cov[1];
      p[0][2] = c.cov[2]; p[2][0] = c.cov[2];
      p[1][1] = c.cov[3];
      p[1][2] = c.cov[4]; p[2][1] = c.cov[4];
      p[2][2] = c.cov[5];
      // T = R * P, kept wide
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          t[i][j] = dot_row(i, p[0][j], p[1][j], p[2][j]);
        end
      end
      // upper triangle of T * R^T
      k = 3;
      for (int i = 0; i < 3; i++) begin
        for (int j = i; j < 3; j++) begin
          r.val[k] = clamp40(dot_row(j, t[i][0], t[i][1], t[i][2]));
          k++;
        end
      end
      return r;
    endfunction

    function void note_command(ecef_cmd_t c);
      pending_ned.push_back(rotate_to_ned(c));
    endfunction

    function void check_result(ned_result_t got);
      ned_result_t exp_r;
      if (pending_ned.size() == 0) begin
        $error("result strobe with no transaction outstanding");
        mismatches++;
        return;
      end
      exp_r = pending_ned.pop_front();
      for (int i = 0; i < 9; i++) begin
        if (got.val[i] !== exp_r.val[i]) begin
          $error("%s: expected %0d, got %0d", field_name[i], exp_r.val[i], got.val[i]);
          mismatches++;
        end
      end
      if (got.cov_valid !== exp_r.cov_valid) begin
        $error("cov_valid: expected %0b, got %0b", exp_r.cov_valid, got.cov_valid);
        mismatches++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CoefW-1:0]    cfg_wdata_i = '0;
  logic                start_i = 1'b0;
  logic                busy_o;
  data_t               vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  data_t               cov_xx_i = '0, cov_xy_i = '0, cov_xz_i = '0;
  data_t               cov_yy_i = '0, cov_yz_i = '0, cov_zz_i = '0;
  logic                cov_present_i = 1'b0;
  logic                res_valid_o;
  data_t               north_o, east_o, down_o;
  data_t               cov_nn_o, cov_ne_o, cov_nd_o, cov_ee_o, cov_ed_o, cov_dd_o;
  logic                cov_valid_o;

  logic [CoefW-1:0]    rot_words [8];
  ned_rotation_sb      rotation_sb = new();

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ecef_to_ned_rotate_covariance_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .vec_x_i       (vec_x_i),
    .vec_y_i       (vec_y_i),
    .vec_z_i       (vec_z_i),
    .cov_xx_i      (cov_xx_i),
    .cov_xy_i      (cov_xy_i),
    .cov_xz_i      (cov_xz_i),
    .cov_yy_i      (cov_yy_i),
    .cov_yz_i      (cov_yz_i),
    .cov_zz_i      (cov_zz_i),
    .cov_present_i (cov_present_i),
    .res_valid_o   (res_valid_o),
    .north_o       (north_o),
    .east_o        (east_o),
    .down_o        (down_o),
    .cov_nn_o      (cov_nn_o),
    .cov_ne_o      (cov_ne_o),
    .cov_nd_o      (cov_nd_o),
    .cov_ee_o      (cov_ee_o),
    .cov_ed_o      (cov_ed_o),
    .cov_dd_o      (cov_dd_o),
    .cov_valid_o   (cov_valid_o)
  );

  // ---------------------------------------------------------------------------
  // Monitor: sample everything at the rising edge, before this step's drives land
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    ecef_cmd_t   seen_cmd;
    ned_result_t seen_res;
    if (rst_ni) begin
      // Mirror register writes at the edge that commits them
      if (cfg_we_i) rotation_sb.write_coef(cfg_idx_i, cfg_wdata_i);
      // Note a command transaction when start meets a free block
      if (start_i && !busy_o) begin
        seen_cmd.vec = '{vec_x_i, vec_y_i, vec_z_i};
        seen_cmd.cov = '{cov_xx_i, cov_xy_i, cov_xz_i, cov_yy_i, cov_yz_i, cov_zz_i};
        seen_cmd.cov_present = cov_present_i;
        rotation_sb.note_command(seen_cmd);
      end
      // Results last one cycle only; check each strobe at once
      if (res_valid_o) begin
        seen_res.val = '{north_o, east_o, down_o, cov_nn_o, cov_ne_o, cov_nd_o,
                         cov_ee_o, cov_ed_o, cov_dd_o};
        seen_res.cov_valid = cov_valid_o;
        rotation_sb.check_result(seen_res);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Write all eight coefficients from rot_words, one per cycle, then drop the enable
  task automatic program_rotation();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CoefOrder[i];
      cfg_wdata_i <= rot_words[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Hold start low through an optional idle gap, then present the command until accepted
  task automatic send_command(input ecef_cmd_t c, input bit idle_on);
    int  gap;
    bit  taken;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    vec_x_i       <= c.vec[0];
    vec_y_i       <= c.vec[1];
    vec_z_i       <= c.vec[2];
    cov_xx_i      <= c.cov[0];
    cov_xy_i      <= c.cov[1];
    cov_xz_i      <= c.cov[2];
    cov_yy_i      <= c.cov[3];
    cov_yz_i      <= c.cov[4];
    cov_zz_i      <= c.cov[5];
    cov_present_i <= c.cov_present;
    // busy is settled by the falling edge, since inputs only move at rising edges
    forever begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
      if (taken) break;
    end
  endtask

  // Drop start, wait for every outstanding result, then let the pipe settle
  task automatic drain_pipe();
    start_i <= 1'b0;
    while (rotation_sb.pending_ned.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic ecef_cmd_t fill_cmd(data_t v, data_t c, logic present);
    ecef_cmd_t r;
    for (int i = 0; i < 3; i++) r.vec[i] = v;
    for (int i = 0; i < 6; i++) r.cov[i] = c;
    r.cov_present = present;
    return r;
  endfunction

  function automatic data_t pick_data();
    longint k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return {8'($urandom), 32'($urandom)};
      4, 5:       return data_t'(int'($urandom_range(0, 131071)) - 65536);
      6: begin
        case ($urandom_range(0, 4))
          0: return DataMax;
          1: return DataMin;
          2: return '0;
          3: return '1;
          default: return 40'sd1;
        endcase
      end
      7: begin
        // odd multiples of 2^29, nudged by one: exact ties for unit-LSB coefficients
        k = 2 * longint'($urandom_range(0, 63)) - 63;
        return data_t'(k * longint'(TieHalf) + longint'($urandom_range(0, 2)) - 1);
      end
      default: return data_t'(longint'($urandom) - 64'sd2147483648);
    endcase
  endfunction

  function automatic ecef_cmd_t random_cmd();
    ecef_cmd_t r;
    for (int i = 0; i < 3; i++) r.vec[i] = pick_data();
    for (int i = 0; i < 6; i++) r.cov[i] = pick_data();
    r.cov_present = ($urandom_range(0, 3) != 0);
    return r;
  endfunction

  // style 0: any 32-bit pattern, 1: within +-1.0, 2: boundary values, 3: mix per register
  function automatic logic [CoefW-1:0] pick_coef(int style);
    int s;
    s = (style == 3) ? $urandom_range(0, 2) : style;
    case (s)
      0: return $urandom;
      1: return 32'(longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824);
      default: begin
        case ($urandom_range(0, 6))
          0: return CoefNegTwo;
          1: return -CoefOne;
          2: return '1;
          3: return '0;
          4: return 32'd1;
          5: return CoefOne;
          default: return CoefMax;
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    ecef_cmd_t cmd;
    bit        idle_on;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity matrix: extremes of every field, covariance on and off
    rot_words = '{CoefOne, '0, '0, '0, CoefOne, '0, '0, CoefOne};
    program_rotation();
    send_command(fill_cmd('0, '0, 1'b1), 1'b0);
    send_command(fill_cmd(DataMax, DataMax, 1'b1), 1'b0);
    send_command(fill_cmd(DataMin, DataMin, 1'b1), 1'b1);
    // Covariance not requested: cov outputs must read zero despite busy inputs
    send_command(fill_cmd(DataMax, DataMin, 1'b0), 1'b0);
    cmd = fill_cmd(DataMax, DataMin, 1'b1);
    cmd.vec[1] = DataMin;
    cmd.vec[2] = 40'sd1;
    cmd.cov[1] = DataMax;
    cmd.cov[4] = '1;
    send_command(cmd, 1'b0);
    drain_pipe();

    // Smallest coefficient: products land on exact half-LSB ties
    rot_words = '{32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1};
    program_rotation();
    cmd = fill_cmd(TieHalf, TieHalf, 1'b1);
    cmd.vec[1] = -TieHalf;
    cmd.vec[2] = TieHalf - 1;
    cmd.cov[1] = -TieHalf;
    cmd.cov[2] = 3 * TieHalf;
    cmd.cov[3] = -(3 * TieHalf);
    cmd.cov[4] = TieHalf + 1;
    cmd.cov[5] = -(TieHalf + 1);
    send_command(cmd, 1'b0);
    send_command(fill_cmd(-TieHalf, TieHalf, 1'b1), 1'b1);
    send_command(fill_cmd(TieHalf + 1, -(TieHalf - 1), 1'b0), 1'b0);
    drain_pipe();

    // Coefficient -2.0: beyond unit range, outputs saturate both ways
    rot_words = '{default: CoefNegTwo};
    program_rotation();
    send_command(fill_cmd(DataMin, DataMin, 1'b1), 1'b0);
    send_command(fill_cmd(DataMax, DataMax, 1'b1), 1'b0);
    send_command(fill_cmd(DataMax, DataMin, 1'b1), 1'b1);
    drain_pipe();

    // Largest positive coefficient
    rot_words = '{default: CoefMax};
    program_rotation();
    send_command(fill_cmd(DataMax, DataMax, 1'b1), 1'b0);
    send_command(fill_cmd(DataMin, DataMax, 1'b1), 1'b0);
    drain_pipe();

    // A real rotation (45 deg latitude and longitude) with random data
    rot_words = '{-CoefHalf, -CoefHalf, CoefRoot2, -CoefRoot2, CoefRoot2,
                  -CoefHalf, -CoefHalf, -CoefRoot2};
    program_rotation();
    repeat (3) send_command(random_cmd(), 1'b1);
    drain_pipe();

    // Random phases: a fresh matrix each time, idle gaps in most phases only
    for (int phase = 0; phase < RandomPhases; phase++) begin
      for (int i = 0; i < 8; i++) rot_words[i] = pick_coef(phase % 4);
      program_rotation();
      idle_on = ($urandom_range(0, 2) != 0);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        send_command(random_cmd(), idle_on);
      end
      drain_pipe();
    end

    if (rotation_sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/e2n_pkg.sv
hw/rtl/e2n_rmul.sv
hw/rtl/e2n_dot3.sv
hw/rtl/ecef_to_ned_rotate_covariance_unit.sv
tb/testbench.sv
